### rtl/srts_pkg.sv
`default_nettype none
package srts_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_W         = 3;
    localparam int FREQ_W       = 17;
    localparam int DIR_W        = 2;
    localparam int PSC_W        = 11;
    localparam int CLK_W        = 32;
    localparam int DVS_W        = PSC_W + FREQ_W;
    localparam int CMP_W        = 31;
    localparam int CFG_IDX_W    = 2;

    localparam logic [DIR_W-1:0] DIR_CW   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_KEEP = 2'd2;
    localparam logic [DIR_W-1:0] DIR_BAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL     = 2'd2;

    localparam logic [CLK_W-1:0]  RST_TIMER_CLK = 32'd96000;
    localparam logic [FREQ_W-1:0] RST_ACCEL     = 17'd100;
    localparam logic [FREQ_W-1:0] RST_DECEL     = 17'd500;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              tgt_clr;
        logic [DIR_W-1:0]  dir;
    } t_ramp_res;

    function automatic logic [PSC_W-1:0] prescale(input logic [FREQ_W-1:0] f);
        logic [PSC_W-1:0] d;
        if (f >= 17'd1000) begin
            d = 11'd2;
        end else if (f >= 17'd100) begin
            d = 11'd20;
        end else if (f >= 17'd10) begin
            d = 11'd200;
        end else begin
            d = 11'd2000;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

### rtl/srts_ramp.sv
`default_nettype none
module srts_ramp (
    input  wire logic [srts_pkg::FREQ_W-1:0] i_cur_freq,
    input  wire logic [srts_pkg::DIR_W-1:0]  i_cur_dir,
    input  wire logic [srts_pkg::FREQ_W-1:0] i_tgt_freq,
    input  wire logic [srts_pkg::DIR_W-1:0]  i_tgt_dir,
    input  wire logic [srts_pkg::FREQ_W-1:0] i_accel,
    input  wire logic [srts_pkg::FREQ_W-1:0] i_decel,
    output srts_pkg::t_ramp_res              o_res
);

    logic                          clr;
    logic [srts_pkg::FREQ_W-1:0]   tgt;
    logic [srts_pkg::FREQ_W:0]     up;
    logic [srts_pkg::FREQ_W:0]     tgt_dn;
    logic [srts_pkg::FREQ_W-1:0]   nf;

    always_comb begin
        clr    = (i_tgt_dir != srts_pkg::DIR_KEEP) && (i_tgt_dir != i_cur_dir);
        tgt    = clr ? '0 : i_tgt_freq;
        up     = {1'b0, i_cur_freq} + {1'b0, i_accel};
        tgt_dn = {1'b0, tgt} + {1'b0, i_decel};
        if ({1'b0, tgt} > up) begin
            nf = up[srts_pkg::FREQ_W-1:0];
        end else if (tgt_dn < {1'b0, i_cur_freq}) begin
            nf = i_cur_freq - i_decel;
        end else begin
            nf = tgt;
        end
        o_res.freq    = nf;
        o_res.tgt_clr = clr;
        o_res.dir     = (nf == '0) ? i_tgt_dir : i_cur_dir;
    end

endmodule
`default_nettype wire

### rtl/srts_div.sv
`default_nettype none
module srts_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [srts_pkg::CLK_W-1:0]   i_dividend,
    input  wire logic [srts_pkg::DVS_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [srts_pkg::CLK_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(srts_pkg::CLK_W);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [srts_pkg::CLK_W-1:0]    r_q, n_q;
    logic [srts_pkg::DVS_W-1:0]    r_rem, n_rem;
    logic [srts_pkg::DVS_W-1:0]    r_dvs, n_dvs;
    logic [srts_pkg::DVS_W:0]      sh;
    logic                          ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        sh     = {r_rem, r_q[srts_pkg::CLK_W-1]};
        ge     = sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? srts_pkg::DVS_W'(sh - {1'b0, r_dvs}) : sh[srts_pkg::DVS_W-1:0];
            n_q   = {r_q[srts_pkg::CLK_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(srts_pkg::CLK_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && $past(r_busy)) |-> (r_rem < r_dvs)) else $error("remainder overflow");

endmodule
`default_nettype wire

### rtl/stepper_ramp_timer_setup_unit.sv
`default_nettype none
// Set request: taken while idle, no result.
// Tick request: six results, one per channel, each through ramp, divider start,
// 32 divide steps and a done step, then output; a stopped channel skips the divider.
// Each result is held until the output takes it; the next request is taken
// in the cycle after the last result leaves.
// Synchronous active-low reset zeroes channel frequencies, sets default directions and restores register defaults.
module stepper_ramp_timer_setup_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // channel, target_frequency, target_direction
    input  wire logic        i_s_tuser,   // kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata,   // out_channel, direction_drive, running,
                                          // prescaler_reg, reload, compare
    output logic             o_m_tlast,   // last
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [srts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RAMP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int N = srts_pkg::NUM_CHANNELS;
    localparam logic [srts_pkg::IDX_W-1:0] LAST_IDX = srts_pkg::IDX_W'(N - 1);

    logic [2:0]                    r_state, n_state;
    logic [srts_pkg::IDX_W-1:0]    r_chan, n_chan;

    logic [srts_pkg::CLK_W-1:0]    r_clk_hz;
    logic [srts_pkg::FREQ_W-1:0]   r_accel, r_decel;

    logic [srts_pkg::FREQ_W-1:0]   r_tgt_freq [N];
    logic [srts_pkg::DIR_W-1:0]    r_tgt_dir  [N];
    logic [srts_pkg::FREQ_W-1:0]   r_cur_freq [N];
    logic [srts_pkg::DIR_W-1:0]    r_cur_dir  [N];

    logic [srts_pkg::FREQ_W-1:0]   r_f;
    logic [srts_pkg::DIR_W-1:0]    r_dir;
    logic [srts_pkg::PSC_W-1:0]    r_pdiv;
    logic [srts_pkg::CLK_W-1:0]    r_reload;

    srts_pkg::t_ramp_res           ramp;
    logic                          div_done;
    logic [srts_pkg::CLK_W-1:0]    div_quot;
    logic [srts_pkg::DVS_W-1:0]    divisor;

    logic                          s_acc, set_ok, run;
    logic [srts_pkg::CH_W-1:0]     s_ch;
    logic [srts_pkg::FREQ_W-1:0]   s_freq;
    logic [srts_pkg::DIR_W-1:0]    s_dir;
    logic [srts_pkg::IDX_W-1:0]    s_idx;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc  = i_s_tvalid && o_s_tready;
    assign s_ch   = i_s_tdata[2:0];
    assign s_freq = i_s_tdata[19:3];
    assign s_dir  = (i_s_tdata[21:20] == srts_pkg::DIR_BAD) ? srts_pkg::DIR_KEEP
                                                            : i_s_tdata[21:20];
    assign s_idx  = srts_pkg::IDX_W'(s_ch);
    assign set_ok = s_acc && !i_s_tuser && ({1'b0, s_ch} < (srts_pkg::CH_W + 1)'(N));

    srts_ramp u_ramp (
        .i_cur_freq (r_cur_freq[r_chan]),
        .i_cur_dir  (r_cur_dir[r_chan]),
        .i_tgt_freq (r_tgt_freq[r_chan]),
        .i_tgt_dir  (r_tgt_dir[r_chan]),
        .i_accel    (r_accel),
        .i_decel    (r_decel),
        .o_res      (ramp)
    );

    assign divisor = srts_pkg::DVS_W'(r_pdiv * r_f);

    srts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_MUL),
        .i_dividend (r_clk_hz),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && i_s_tuser) begin
                    n_chan  = '0;
                    n_state = ST_RAMP;
                end
            end
            ST_RAMP: n_state = (ramp.freq == '0) ? ST_OUT : ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    if (r_chan == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_state = ST_RAMP;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chan   <= '0;
            r_clk_hz <= srts_pkg::RST_TIMER_CLK;
            r_accel  <= srts_pkg::RST_ACCEL;
            r_decel  <= srts_pkg::RST_DECEL;
            for (int i = 0; i < N; i++) begin
                r_tgt_freq[i] <= '0;
                r_tgt_dir[i]  <= srts_pkg::DIR_CW;
                r_cur_freq[i] <= '0;
                r_cur_dir[i]  <= srts_pkg::DIR_KEEP;
            end
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    srts_pkg::CFG_TIMER_CLK: r_clk_hz <= i_cfg_data;
                    srts_pkg::CFG_ACCEL:     r_accel  <= i_cfg_data[srts_pkg::FREQ_W-1:0];
                    srts_pkg::CFG_DECEL:     r_decel  <= i_cfg_data[srts_pkg::FREQ_W-1:0];
                    default: ;
                endcase
            end
            if (set_ok) begin
                r_tgt_freq[s_idx] <= s_freq;
                r_tgt_dir[s_idx]  <= s_dir;
            end
            if (r_state == ST_RAMP) begin
                if (ramp.tgt_clr) begin
                    r_tgt_freq[r_chan] <= '0;
                end
                r_cur_freq[r_chan] <= ramp.freq;
                r_cur_dir[r_chan]  <= ramp.dir;
            end
        end
        if (r_state == ST_RAMP) begin
            r_f      <= ramp.freq;
            r_dir    <= ramp.dir;
            r_pdiv   <= srts_pkg::prescale(ramp.freq);
            r_reload <= '0;
        end else if (r_state == ST_DIV && div_done) begin
            r_reload <= div_quot;
        end
    end

    assign run        = (r_f != '0);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tlast  = (r_chan == LAST_IDX);
    assign o_m_tdata  = {
        r_reload[srts_pkg::CLK_W-1:1],
        r_reload,
        run ? (r_pdiv - 1'b1) : {srts_pkg::PSC_W{1'b0}},
        run,
        r_dir,
        srts_pkg::CH_W'(r_chan)
    };

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[5]) |-> (o_m_tdata[79:6] == '0))
        else $error("stopped channel carries timer settings");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (r_state == ST_IDLE))
        else $error("tick not finished after last result");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide phase");
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_chan <= LAST_IDX))
        else $error("channel counter out of range");

endmodule
`default_nettype wire
